### rtl/core/kptt_pkg.sv
// ----------------------------------------------------------------------------
// kptt_pkg: keyed priority task table shared definitions
// Item types, operation and status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kptt_pkg;

  localparam int OP_W   = 2;
  localparam int TASK_W = 6;
  localparam int USER_W = 16;
  localparam int PRIO_W = 16;
  localparam int STAT_W = 2;

  localparam int NUM_TASKS_DEF     = 64;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int USER_BITS_DEF     = 16;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_EDIT   = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_EXEC   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [TASK_W-1:0] task_id;
    logic [USER_W-1:0] user_id;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [USER_W-1:0] top_user;
    logic [TASK_W-1:0] top_task;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY,
    S_SCAN,
    S_RETIRE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear_wr;
    logic scan_step;
    logic modify;
    logic retire;
  } dp_cmd_t;

  typedef struct packed {
    logic req_exec;
    logic req_lookup;
    logic clear_last;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/kptt_dp.sv
// ----------------------------------------------------------------------------
// kptt_dp: keyed priority task table datapath
// Task memory, scan index, request and best-candidate registers and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kptt_dp #(
  parameter int NUM_TASKS     = kptt_pkg::NUM_TASKS_DEF,
  parameter int PRIORITY_BITS = kptt_pkg::PRIORITY_BITS_DEF,
  parameter int USER_BITS     = kptt_pkg::USER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kptt_pkg::dp_cmd_t   cmd,
  output kptt_pkg::dp_stat_t  stat,
  input  kptt_pkg::in_item_t  in_item,
  input  logic                out_stall,
  output logic                out_valid,
  output kptt_pkg::out_item_t out_item
);
  import kptt_pkg::*;

  localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int WORD_W = 1 + PRIORITY_BITS + USER_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  logic [WORD_W-1:0] mem_r [NUM_TASKS];
  logic [WORD_W-1:0] rdata_r;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              we;

  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [OP_W-1:0]          req_op_r, req_op_nxt;
  logic [PRIORITY_BITS-1:0] req_prio_r, req_prio_nxt;

  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [PRIORITY_BITS-1:0] best_prio_r, best_prio_nxt;
  logic [USER_BITS-1:0]     best_user_r, best_user_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      load_out;

  logic                     rd_valid;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [USER_BITS-1:0]     rd_user;
  logic [IDX_W-1:0]         in_addr;
  logic                     in_id_ok;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic [USER_BITS-1:0]     in_user;
  logic                     take;

  assign rd_valid = rdata_r[WORD_W-1];
  assign rd_prio  = rdata_r[PRIORITY_BITS+USER_BITS-1 -: PRIORITY_BITS];
  assign rd_user  = rdata_r[USER_BITS-1:0];

  assign in_addr  = IDX_W'(in_item.task_id);
  assign in_id_ok = 32'(in_item.task_id) < 32'(NUM_TASKS);
  assign in_prio  = PRIORITY_BITS'(in_item.priority_req);
  assign in_user  = USER_BITS'(in_item.user_id);

  assign take = rd_valid && (!found_r || (rd_prio >= best_prio_r));

  assign stat.req_exec   = (in_item.operation == OP_EXEC);
  assign stat.req_lookup = (in_item.operation == OP_EDIT || in_item.operation == OP_REMOVE)
                           && in_id_ok;
  assign stat.clear_last = (idx_r == LAST_IDX);
  assign stat.scan_last  = (idx_r == LAST_IDX);
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    raddr         = idx_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = '0;
    idx_nxt       = idx_r;
    req_op_nxt    = req_op_r;
    req_prio_nxt  = req_prio_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_user_nxt = best_user_r;
    load_out      = 1'b0;
    out_item_nxt  = out_item_r;

    priority if (cmd.clear_wr) begin
      we      = 1'b1;
      idx_nxt = stat.clear_last ? '0 : idx_r + IDX_W'(1);
    end else if (cmd.accept) begin
      req_op_nxt   = in_item.operation;
      req_prio_nxt = in_prio;
      priority if (in_item.operation == OP_EXEC) begin
        raddr     = '0;
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end else if (!in_id_ok) begin
        load_out     = 1'b1;
        out_item_nxt = '{status: STAT_NOT_FOUND, top_user: '0, top_task: '0};
      end else if (in_item.operation == OP_ADD) begin
        we           = 1'b1;
        waddr        = in_addr;
        wdata        = {1'b1, in_prio, in_user};
        load_out     = 1'b1;
        out_item_nxt = '{status: STAT_OK, top_user: '0, top_task: '0};
      end else begin
        raddr = in_addr;
        idx_nxt = in_addr;
      end
    end else if (cmd.scan_step) begin
      if (take) begin
        found_nxt     = 1'b1;
        best_idx_nxt  = idx_r;
        best_prio_nxt = rd_prio;
        best_user_nxt = rd_user;
      end
      if (!stat.scan_last) begin
        idx_nxt = idx_r + IDX_W'(1);
        raddr   = idx_r + IDX_W'(1);
      end
    end else if (cmd.modify) begin
      load_out = 1'b1;
      priority if (!rd_valid) begin
        out_item_nxt = '{status: STAT_NOT_FOUND, top_user: '0, top_task: '0};
      end else if (req_op_r == OP_EDIT) begin
        we           = 1'b1;
        wdata        = {1'b1, req_prio_r, rd_user};
        out_item_nxt = '{status: STAT_OK, top_user: '0, top_task: '0};
      end else begin
        we           = 1'b1;
        wdata        = {1'b0, rd_prio, rd_user};
        out_item_nxt = '{status: STAT_OK, top_user: '0, top_task: '0};
      end
    end else if (cmd.retire) begin
      load_out = 1'b1;
      if (found_r) begin
        we           = 1'b1;
        waddr        = best_idx_r;
        wdata        = {1'b0, best_prio_r, best_user_r};
        out_item_nxt = '{status: STAT_OK, top_user: USER_W'(best_user_r),
                         top_task: TASK_W'(best_idx_r)};
      end else begin
        out_item_nxt = '{status: STAT_EMPTY, top_user: '0, top_task: '0};
      end
    end

    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);
  end

  // task memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_op_r    <= req_op_nxt;
    req_prio_r  <= req_prio_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_user_r <= best_user_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("table index out of range");

  a_modify_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.modify |-> $past(cmd.accept))
    else $error("modify without a preceding lookup");

endmodule

`default_nettype wire

### rtl/core/kptt_ctrl.sv
// ----------------------------------------------------------------------------
// kptt_ctrl: keyed priority task table controller
// Sequences the clearing pass, input acceptance, lookups and the
// one-entry-per-cycle scan for execute top.
// ----------------------------------------------------------------------------
`default_nettype none

module kptt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kptt_pkg::dp_stat_t stat,
  output kptt_pkg::dp_cmd_t  cmd
);
  import kptt_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall   = !stat.out_free;
        accept     = in_valid && stat.out_free;
        cmd.accept = accept;
        if (accept) begin
          priority if (stat.req_exec) begin
            state_nxt = S_SCAN;
          end else if (stat.req_lookup) begin
            state_nxt = S_MODIFY;
          end
        end
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_RETIRE;
        end
      end
      S_RETIRE: begin
        cmd.retire = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_scan_to_retire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.scan_last) |=> state_r == S_RETIRE)
    else $error("scan did not end in retire");

  a_modify_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MODIFY |=> state_r == S_IDLE)
    else $error("modify held longer than one cycle");

  a_retire_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RETIRE |-> $past(state_r) == S_SCAN)
    else $error("retire entered without a scan");

endmodule

`default_nettype wire

### rtl/core/keyed_priority_task_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_priority_task_table_unit: indexed priority queue of tasks
// Table of tasks addressed by id, each with a priority and an owning user.
//
// Input channel in_valid/in_stall/in_item carries one operation per transfer:
// add, edit priority, remove or execute top. Output channel
// out_valid/out_stall/out_item returns exactly one result per operation.
// Results: add, or any id outside the table, loads the result register at the
// transfer; edit and remove do one registered memory read, then the write
// back with the result; execute top scans the table, reading one table entry
// per cycle from the single-read-port task memory, then retires the best one.
// One operation is in flight at a time; a result waiting in the output
// register does not block the next transfer as long as it drains first.
// After reset a clearing pass marks every entry invalid, with in_stall high
// throughout. While out_stall is high a waiting result holds, and in the idle
// state in_stall stays high until that result drains.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_priority_task_table_unit #(
  parameter int NUM_TASKS     = kptt_pkg::NUM_TASKS_DEF,
  parameter int PRIORITY_BITS = kptt_pkg::PRIORITY_BITS_DEF,
  parameter int USER_BITS     = kptt_pkg::USER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kptt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output kptt_pkg::out_item_t out_item
);
  import kptt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  kptt_dp #(
    .NUM_TASKS     (NUM_TASKS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .USER_BITS     (USER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
